// ===== design/tcw_pkg.sv =====
// Package for the text console writer: geometry constants, character codes,
// request codes and the address request type shared by the core and its units.
// No dependencies.
package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STOP = 8;
    localparam int CELLS    = ROWS * COLUMNS;

    // Derived widths
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int MOD_W  = $clog2(TAB_STOP);
    localparam int TCOL_W = $clog2(COLUMNS + TAB_STOP);

    // Field widths
    localparam int CELL_W    = 16;
    localparam int CHAR_W    = 8;
    localparam int ATTR_W    = 8;
    localparam int COLOR_W   = 4;
    localparam int RROW_W    = 5;
    localparam int RCOL_W    = 7;
    localparam int POS_W     = 11;
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_BS         = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_TAB        = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_LF         = 8'h0a;
    localparam logic [CHAR_W-1:0] CHAR_CR         = 8'h0d;
    localparam logic [CHAR_W-1:0] CHAR_FIRST_PRINT = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_LAST_PRINT  = 8'h7f;
    localparam logic [CHAR_W-1:0] BLANK_CHAR      = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTR      = 8'h0f;

    // Request kinds
    typedef enum logic [1:0] {
        REQ_PUT   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NOP   = 2'd3
    } t_req_type;

    // Request to the address unit: logical cell, with or without row rotation
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             rotate;
    } t_addr_req;

endpackage

// ===== design/tcw_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, read or both, at the single address
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/tcw_addr_unit.sv =====
// Shared address unit: maps a logical (row, column) to a screen RAM address,
// applying the rotating top-row offset when asked. Depends on tcw_pkg.
module tcw_addr_unit (
    input  tcw_pkg::t_addr_req             i_req,
    input  logic [tcw_pkg::ROW_W-1:0]      i_top,
    output logic [tcw_pkg::ADDR_W-1:0]     o_addr
);
    import tcw_pkg::*;

    logic [ROW_W:0]   w_sum;
    logic [ROW_W-1:0] w_prow;

    // Physical row = logical row + top, modulo ROWS
    assign w_sum  = {1'b0, i_req.row} + (i_req.rotate ? {1'b0, i_top} : '0);
    assign w_prow = (w_sum >= (ROW_W+1)'(ROWS)) ? ROW_W'(w_sum - (ROW_W+1)'(ROWS))
                                                : ROW_W'(w_sum);

    // Linear address
    assign o_addr = ADDR_W'(w_prow) * ADDR_W'(COLUMNS) + ADDR_W'(i_req.col);

endmodule

// ===== design/text_console_writer_core.sv =====
// Top level of the text console writer: request sequencer, cursor state and
// screen store. Depends on tcw_pkg, tcw_ram and tcw_addr_unit.
//
// Usage:
//   Slave channel (i_s_*) takes requests: tuser holds the request kind
//   (0 put character, 1 clear screen, 2 read cell, 3 no-op); tdata the character,
//   colours and read coordinates. Master channel (o_m_*) returns one result
//   per request: cursor position and the cell read (zero unless a read).
//   i_cfg_wr_en/i_cfg_wr_data write the blank attribute; write it only idle.
// Timing:
//   A request is taken only while the sequencer is idle, so the next one waits
//   until the last result is loaded into the output register. A put that
//   scrolls adds a sweep: the top row offset rotates and only the new bottom
//   row is blanked, one cell a cycle through the single RAM port. A clear
//   sweeps every cell of the screen, one cell a cycle.
// Reset:
//   The whole screen is blanked with attribute 0x0f, with o_s_tready
//   low; configuration writes are taken.
// Stalls:
//   A result waits in the output register while i_m_tready is low; the next
//   request is still taken and its result waits for the register to free.
module text_console_writer_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Requests
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [7:0] char_code, [11:8] fg_color, [15:12] bg_color,
    // [20:16] read_row, [27:21] read_column, [31:28] zero
    input  logic [tcw_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // [1:0] req_type
    input  logic [tcw_pkg::S_TUSER_W-1:0]  i_s_tuser,
    // Results
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [10:0] cursor_position, [26:11] cell_value, [31:27] zero
    output logic [tcw_pkg::M_TDATA_W-1:0]  o_m_tdata,
    // Configuration
    input  logic                           i_cfg_wr_en,
    input  logic [tcw_pkg::ATTR_W-1:0]     i_cfg_wr_data
);
    import tcw_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SWEEP,
        S_DONE
    } t_state;

    t_state             r_state;
    t_req_type          r_req;
    logic [CHAR_W-1:0]  r_char;
    logic [COLOR_W-1:0] r_fg;
    logic [COLOR_W-1:0] r_bg;
    logic [RROW_W-1:0]  r_rd_row;
    logic [RCOL_W-1:0]  r_rd_col;
    logic               r_rd_hit;

    logic [ROW_W-1:0]   r_cur_row;
    logic [COL_W-1:0]   r_cur_col;
    logic [MOD_W-1:0]   r_col_mod;
    logic [ROW_W-1:0]   r_top;

    logic [ATTR_W-1:0]  r_blank_attr;
    logic [ATTR_W-1:0]  r_sw_attr;
    logic [ROW_W-1:0]   r_sw_row;
    logic [COL_W-1:0]   r_sw_col;
    logic               r_sw_reply;

    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    // Put-character next state
    logic [ROW_W-1:0]   n_row;
    logic [COL_W-1:0]   n_col;
    logic [MOD_W-1:0]   n_mod;
    logic [ROW_W-1:0]   n_top;
    logic               n_scroll;
    logic               n_print;
    logic               w_adv;
    logic [TCOL_W-1:0]  w_tab_col;
    logic [MOD_W-1:0]   w_mod_inc;

    t_addr_req          w_areq;
    logic [ADDR_W-1:0]  w_addr;
    logic               w_we;
    logic               w_re;
    logic [CELL_W-1:0]  w_wdata;
    logic [CELL_W-1:0]  w_rdata;
    logic [CELL_W-1:0]  w_cell;
    logic               w_accept;
    logic               w_sw_end;
    logic               w_out_load;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || i_m_tready);

    // Cursor update for a put request
    assign w_tab_col = TCOL_W'(r_cur_col) + TCOL_W'(TAB_STOP) - TCOL_W'(r_col_mod);
    assign w_mod_inc = (r_col_mod == MOD_W'(TAB_STOP - 1)) ? '0 : r_col_mod + 1'b1;
    assign n_top     = (r_top == ROW_W'(ROWS - 1)) ? '0 : r_top + 1'b1;

    always_comb begin
        n_col   = r_cur_col;
        n_mod   = r_col_mod;
        w_adv   = 1'b0;
        n_print = 1'b0;
        case (r_char) inside
            CHAR_BS: begin
                if (r_cur_col != '0) begin
                    n_col = r_cur_col - 1'b1;
                    n_mod = (r_col_mod == '0) ? MOD_W'(TAB_STOP - 1) : r_col_mod - 1'b1;
                end
            end
            CHAR_TAB: begin
                if (w_tab_col >= TCOL_W'(COLUMNS)) begin
                    n_col = '0;
                    w_adv = 1'b1;
                end else begin
                    n_col = COL_W'(w_tab_col);
                end
                n_mod = '0;
            end
            CHAR_CR: begin
                n_col = '0;
                n_mod = '0;
            end
            CHAR_LF: begin
                n_col = '0;
                n_mod = '0;
                w_adv = 1'b1;
            end
            [CHAR_FIRST_PRINT:CHAR_LAST_PRINT]: begin
                n_print = 1'b1;
                if (r_cur_col == COL_W'(COLUMNS - 1)) begin
                    n_col = '0;
                    n_mod = '0;
                    w_adv = 1'b1;
                end else begin
                    n_col = r_cur_col + 1'b1;
                    n_mod = w_mod_inc;
                end
            end
            default: ;
        endcase
        n_scroll = w_adv && (r_cur_row == ROW_W'(ROWS - 1));
        n_row    = (w_adv && !n_scroll) ? r_cur_row + 1'b1 : r_cur_row;
    end

    // Address unit request, chosen by the sequencer step
    always_comb begin
        case (r_state)
            S_SWEEP: w_areq = '{row: r_sw_row, col: r_sw_col, rotate: 1'b1};
            S_EXEC: begin
                if (r_req == REQ_READ) begin
                    w_areq = '{row: ROW_W'(r_rd_row), col: COL_W'(r_rd_col), rotate: 1'b1};
                end else begin
                    w_areq = '{row: r_cur_row, col: r_cur_col, rotate: 1'b1};
                end
            end
            default: w_areq = '{row: r_cur_row, col: r_cur_col, rotate: 1'b0};
        endcase
    end

    tcw_addr_unit u_addr (
        .i_req  (w_areq),
        .i_top  (r_top),
        .o_addr (w_addr)
    );

    // Screen store port
    assign w_we    = (r_state == S_SWEEP) ||
                     ((r_state == S_EXEC) && (r_req == REQ_PUT) && n_print);
    assign w_re    = (r_state == S_EXEC) && (r_req == REQ_READ);
    assign w_wdata = (r_state == S_SWEEP) ? {r_sw_attr, BLANK_CHAR} : {r_bg, r_fg, r_char};

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_re    (w_re),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    assign w_sw_end = (r_sw_col == COL_W'(COLUMNS - 1)) && (r_sw_row == ROW_W'(ROWS - 1));
    assign w_cell   = ((r_req == REQ_READ) && r_rd_hit) ? w_rdata : '0;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank_attr <= RESET_ATTR;
        end else if (i_cfg_wr_en) begin
            r_blank_attr <= i_cfg_wr_data;
        end
    end

    // Sequencer, cursor and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_col_mod   <= '0;
            r_top       <= '0;
            r_sw_attr   <= RESET_ATTR;
            r_sw_row    <= '0;
            r_sw_col    <= '0;
            r_sw_reply  <= 1'b0;
            r_out_valid <= 1'b0;
            r_rd_hit    <= 1'b0;
        end else begin
            // Output register: load a new result or hand the current one over
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_req    <= t_req_type'(i_s_tuser[1:0]);
                        r_char   <= i_s_tdata[7:0];
                        r_fg     <= i_s_tdata[11:8];
                        r_bg     <= i_s_tdata[15:12];
                        r_rd_row <= i_s_tdata[20:16];
                        r_rd_col <= i_s_tdata[27:21];
                        r_state  <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_rd_hit <= (r_req == REQ_READ) && (int'(r_rd_row) < ROWS) &&
                                (int'(r_rd_col) < COLUMNS);
                    case (r_req)
                        REQ_PUT: begin
                            r_cur_row <= n_row;
                            r_cur_col <= n_col;
                            r_col_mod <= n_mod;
                            if (n_scroll) begin
                                r_top      <= n_top;
                                r_sw_attr  <= r_blank_attr;
                                r_sw_row   <= ROW_W'(ROWS - 1);
                                r_sw_col   <= '0;
                                r_sw_reply <= 1'b1;
                                r_state    <= S_SWEEP;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        REQ_CLEAR: begin
                            r_cur_row  <= '0;
                            r_cur_col  <= '0;
                            r_col_mod  <= '0;
                            r_top      <= '0;
                            r_sw_attr  <= r_blank_attr;
                            r_sw_row   <= '0;
                            r_sw_col   <= '0;
                            r_sw_reply <= 1'b1;
                            r_state    <= S_SWEEP;
                        end
                        REQ_READ: begin
                            r_state <= S_DONE;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_SWEEP: begin
                    if (w_sw_end) begin
                        r_state <= r_sw_reply ? S_DONE : S_IDLE;
                    end else if (r_sw_col == COL_W'(COLUMNS - 1)) begin
                        r_sw_col <= '0;
                        r_sw_row <= r_sw_row + 1'b1;
                    end else begin
                        r_sw_col <= r_sw_col + 1'b1;
                    end
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_out_data <= M_TDATA_W'({w_cell, POS_W'(w_addr)});
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Checks
    a_cursor_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cur_row) < ROWS)
        else $error("cursor row beyond last row");

    a_cursor_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cur_col) < COLUMNS)
        else $error("cursor column beyond last column");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC))
        else $error("accepted transaction not executed");

    a_write_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> ((r_state == S_SWEEP) || (r_state == S_EXEC)))
        else $error("screen write outside execute or sweep");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> (r_out_valid && $stable(r_out_data)))
        else $error("pending result lost");

endmodule

// ===== verif/text_console_writer_core_tb.sv =====
// Self-checking testbench for text_console_writer_core: drives put, clear,
// read and no-op requests, writes the blank attribute and checks every result
// against a console predictor held in the bench. Depends on tcw_pkg and text_console_writer_core.
`timescale 1ns / 100ps

module text_console_writer_core_tb;

    import tcw_pkg::*;

    localparam int unsigned RUN_LIMIT   = 1_000_000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned TAIL_CYCLES = 200;

    // One result transaction: cursor position and cell read
    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [CELL_W-1:0] cell_value;
    } console_result_t;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_s_tvalid    = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata     = '0;
    logic [S_TUSER_W-1:0]  i_s_tuser     = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [ATTR_W-1:0]     i_cfg_wr_data = '0;

    // Predictor state
    logic [CELL_W-1:0] screen_mem [CELLS];
    int unsigned       cur_col;
    int unsigned       cur_row;
    logic [ATTR_W-1:0] blank_attr;

    console_result_t pending_results [$];
    int unsigned     mismatch_count = 0;
    int unsigned     cycle_count    = 0;
    int unsigned     src_idle_pct   = 0;
    int unsigned     sink_idle_pct  = 0;
    int unsigned     hold_requests  = 0;
    int unsigned     hold_served    = 0;
    int unsigned     hold_left      = 0;

    text_console_writer_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= RUN_LIMIT);
        $display("%0t: timeout, %0d results still outstanding", $time, pending_results.size());
        $display("TEST FAILED");
        $finish;
    end

    // Predictor: blank cell for the current attribute
    function automatic logic [CELL_W-1:0] blank_word();
        return {blank_attr, BLANK_CHAR};
    endfunction

    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++) screen_mem[i] = blank_word();
        cur_col = 0;
        cur_row = 0;
    endfunction

    // Predictor: apply one request, return the result it should produce
    function automatic console_result_t console_update(input t_req_type kind,
                                                      input logic [CHAR_W-1:0] ch,
                                                      input logic [COLOR_W-1:0] fg,
                                                      input logic [COLOR_W-1:0] bg,
                                                      input logic [RROW_W-1:0] rr,
                                                      input logic [RCOL_W-1:0] rc);
        console_result_t res;
        res.cell_value = '0;
        case (kind)
            REQ_PUT: begin
                if (ch == CHAR_BS) begin
                    if (cur_col != 0) cur_col--;
                end else if (ch == CHAR_TAB) begin
                    cur_col = (cur_col / TAB_STOP + 1) * TAB_STOP;
                end else if (ch == CHAR_CR) begin
                    cur_col = 0;
                end else if (ch == CHAR_LF) begin
                    cur_col = 0;
                    cur_row++;
                end else if (ch >= CHAR_FIRST_PRINT && ch <= CHAR_LAST_PRINT) begin
                    screen_mem[cur_row * COLUMNS + cur_col] = {bg, fg, ch};
                    cur_col++;
                end
                // wrap past the last column
                if (cur_col >= COLUMNS) begin
                    cur_col = 0;
                    cur_row++;
                end
                // scroll past the last row
                if (cur_row >= ROWS) begin
                    for (int i = 0; i < CELLS - COLUMNS; i++)
                        screen_mem[i] = screen_mem[i + COLUMNS];
                    for (int i = CELLS - COLUMNS; i < CELLS; i++)
                        screen_mem[i] = blank_word();
                    cur_row = ROWS - 1;
                end
            end
            REQ_CLEAR: blank_screen();
            REQ_READ: begin
                if (rr < ROWS && rc < COLUMNS) res.cell_value = screen_mem[rr * COLUMNS + rc];
            end
            default: ;
        endcase
        res.pos = POS_W'(cur_row * COLUMNS + cur_col);
        return res;
    endfunction

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            i_m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        console_result_t want;
        console_result_t got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.pos        = o_m_tdata[POS_W-1:0];
            got.cell_value = o_m_tdata[POS_W+CELL_W-1:POS_W];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got pos %0d cell %h",
                         $time, got.pos, got.cell_value);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.pos !== want.pos) begin
                    $display("%0t: cursor_position expected %0d got %0d",
                             $time, want.pos, got.pos);
                    mismatch_count++;
                end
                if (got.cell_value !== want.cell_value) begin
                    $display("%0t: cell_value expected %h got %h",
                             $time, want.cell_value, got.cell_value);
                    mismatch_count++;
                end
            end
        end
    end

    // Send one request and record its expected result once accepted
    task automatic send_request(input t_req_type kind, input logic [CHAR_W-1:0] ch,
                                input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg,
                                input logic [RROW_W-1:0] rr, input logic [RCOL_W-1:0] rc);
        int unsigned gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < src_idle_pct) gap++;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'b0, rc, rr, bg, fg, ch};
        i_s_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_tready);
        pending_results.push_back(console_update(kind, ch, fg, bg, rr, rc));
    endtask

    // Request shorthands; unused fields carry random bits
    task automatic put_char(input logic [CHAR_W-1:0] ch, input logic [COLOR_W-1:0] fg,
                            input logic [COLOR_W-1:0] bg);
        send_request(REQ_PUT, ch, fg, bg, RROW_W'($urandom_range(31)),
                     RCOL_W'($urandom_range(127)));
    endtask

    task automatic put_printable();
        put_char(CHAR_W'($urandom_range(CHAR_FIRST_PRINT, CHAR_LAST_PRINT)),
                 COLOR_W'($urandom_range(15)), COLOR_W'($urandom_range(15)));
    endtask

    task automatic read_cell(input logic [RROW_W-1:0] rr, input logic [RCOL_W-1:0] rc);
        send_request(REQ_READ, CHAR_W'($urandom_range(255)), COLOR_W'($urandom_range(15)),
                     COLOR_W'($urandom_range(15)), rr, rc);
    endtask

    task automatic other_request(input t_req_type kind);
        send_request(kind, CHAR_W'($urandom_range(255)), COLOR_W'($urandom_range(15)),
                     COLOR_W'($urandom_range(15)), RROW_W'($urandom_range(31)),
                     RCOL_W'($urandom_range(127)));
    endtask

    // Stop offering and wait until every result is back
    task automatic wait_results_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Attribute write; only called while the block is idle
    task automatic write_blank_attr(input logic [ATTR_W-1:0] attr);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= attr;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        blank_attr = attr;
    endtask

    // Field extremes, every request kind and the corner cases
    task automatic test_directed_requests();
        read_cell(0, 0);
        put_char(8'h41, 4'hf, 4'hf);
        put_char(CHAR_LAST_PRINT, 4'h0, 4'h0);
        put_char(CHAR_FIRST_PRINT, 4'h5, 4'ha);
        read_cell(0, 0);
        read_cell(0, 1);
        repeat (4) put_char(CHAR_BS, 4'h3, 4'hc);   // last one at column zero
        put_char(CHAR_TAB, 4'h0, 4'h0);
        put_char(8'h78, 4'h9, 4'h6);
        put_char(CHAR_CR, 4'h0, 4'h0);
        put_char(CHAR_LF, 4'h0, 4'h0);
        // ignored control codes and high bytes
        put_char(8'h00, 4'hf, 4'hf);
        put_char(8'h1f, 4'hf, 4'hf);
        put_char(8'h80, 4'hf, 4'hf);
        put_char(8'hff, 4'hf, 4'hf);
        // reads at and beyond the screen edge
        read_cell(5'd31, 7'd127);
        read_cell(RROW_W'(ROWS - 1), RCOL_W'(COLUMNS - 1));
        read_cell(RROW_W'(ROWS), 0);
        read_cell(0, RCOL_W'(COLUMNS));
        other_request(REQ_NOP);
        other_request(REQ_CLEAR);
        read_cell(0, 0);
        wait_results_drained();
    endtask

    // Column wrap, tab wrap, scrolling at the bottom row
    task automatic test_wrap_and_scroll();
        other_request(REQ_CLEAR);
        repeat (COLUMNS) put_printable();
        read_cell(0, RCOL_W'(COLUMNS - 1));
        repeat (COLUMNS / TAB_STOP) put_char(CHAR_TAB, 4'h1, 4'h2);
        put_printable();
        repeat (ROWS) put_char(CHAR_LF, 4'h0, 4'h0);
        read_cell(0, 0);
        read_cell(RROW_W'(ROWS - 1), 0);
        // fill the bottom row so the wrap itself scrolls
        repeat (COLUMNS) put_printable();
        put_char(CHAR_BS, 4'h0, 4'h0);
        read_cell(RROW_W'(ROWS - 2), 0);
        read_cell(RROW_W'(ROWS - 2), RCOL_W'(COLUMNS - 1));
        read_cell(RROW_W'(ROWS - 1), 3);
        wait_results_drained();
    endtask

    // Blank attribute at both extremes: 0x00 for a clear, 0xff for a scroll
    task automatic test_blank_attribute();
        write_blank_attr(8'h00);
        other_request(REQ_CLEAR);
        read_cell(0, 0);
        read_cell(RROW_W'(ROWS - 1), RCOL_W'(COLUMNS - 1));
        put_printable();
        wait_results_drained();
        write_blank_attr(8'hff);
        repeat (ROWS) put_char(CHAR_LF, 4'h0, 4'h0);
        read_cell(RROW_W'(ROWS - 1), 7);
        read_cell(0, 0);
        read_cell(RROW_W'(ROWS - 2), 0);
        wait_results_drained();
    endtask

    // Receiver holds off long enough for the input side to stall
    task automatic test_output_backpressure();
        int unsigned saved_idle;
        saved_idle   = src_idle_pct;
        src_idle_pct = 0;
        hold_requests++;
        repeat (12) put_printable();
        put_char(CHAR_LF, 4'h0, 4'h0);
        read_cell(0, 0);
        wait_results_drained();
        src_idle_pct = saved_idle;
    endtask

    // Random traffic, mostly printing with moves, reads and rare clears
    task automatic test_random_traffic(input int unsigned count);
        int unsigned pick;
        int unsigned sub;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(999);
            if (pick < 12) begin
                other_request(REQ_CLEAR);
            end else if (pick < 30) begin
                other_request(REQ_NOP);
            end else if (pick < 220) begin
                read_cell(RROW_W'(($urandom_range(9) == 0) ? $urandom_range(31)
                                                           : $urandom_range(ROWS - 1)),
                          RCOL_W'(($urandom_range(9) == 0) ? $urandom_range(127)
                                                           : $urandom_range(COLUMNS - 1)));
            end else begin
                sub = $urandom_range(99);
                if (sub < 8)       put_char(CHAR_LF, COLOR_W'($urandom_range(15)),
                                            COLOR_W'($urandom_range(15)));
                else if (sub < 13) put_char(CHAR_TAB, COLOR_W'($urandom_range(15)),
                                            COLOR_W'($urandom_range(15)));
                else if (sub < 18) put_char(CHAR_BS, COLOR_W'($urandom_range(15)),
                                            COLOR_W'($urandom_range(15)));
                else if (sub < 21) put_char(CHAR_CR, COLOR_W'($urandom_range(15)),
                                            COLOR_W'($urandom_range(15)));
                else if (sub < 25) put_char(CHAR_W'($urandom_range(255)),
                                            COLOR_W'($urandom_range(15)),
                                            COLOR_W'($urandom_range(15)));
                else               put_printable();
            end
        end
        wait_results_drained();
    endtask

    // Sequence of tests
    initial begin
        blank_attr = RESET_ATTR;
        blank_screen();
        src_idle_pct  = 6;
        sink_idle_pct = 80;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_requests();
        test_wrap_and_scroll();
        test_blank_attribute();
        test_output_backpressure();

        write_blank_attr(ATTR_W'($urandom_range(255)));
        test_random_traffic(42);

        src_idle_pct  = 80;
        sink_idle_pct = 6;
        write_blank_attr(ATTR_W'($urandom_range(255)));
        test_random_traffic(42);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_blank_attr(RESET_ATTR);
        test_random_traffic(42);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/tcw_pkg.sv
design/tcw_ram.sv
design/tcw_addr_unit.sv
design/text_console_writer_core.sv
verif/text_console_writer_core_tb.sv
